>>> hdl/rle_palette_sprite_decoder_core_macros.svh
// Assertion macros shared by the sprite decoder modules.
`ifndef RLE_PALETTE_SPRITE_DECODER_CORE_MACROS_SVH
`define RLE_PALETTE_SPRITE_DECODER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RPSD_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define RPSD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/rpsd_pkg.sv
// Shared constants and controller/datapath interface types for the sprite decoder.
`timescale 1ns / 1ps
package rpsd_pkg;

   localparam int DIM_BITS_DEF        = 12;
   localparam int PALETTE_ENTRIES_DEF = 256;

   localparam int ACTION_W   = 2;
   localparam int BYTE_W     = 8;
   localparam int COLOR_W    = 16;
   localparam int POS_W      = 12;
   localparam int SKIP_W     = 12;
   localparam int CFG_W      = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;

   // word actions on req_tuser
   localparam logic [ACTION_W-1:0] ACT_BYTE    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_PALETTE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_START   = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_SPARE   = 2'd3;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_SKIP = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_SKIP   = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic take;       // input word accepted this cycle
      logic run_step;   // advance the transparent run by one step
      logic load_out;   // move the pending result into the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic start_run;  // word on the input starts a transparent run
      logic start_emit; // word on the input produces a result
      logic run_last;   // this run step ends the run
      logic run_emit;   // this run step completes the image
      logic out_free;   // output register can take a result
   } sts_type;

endpackage

>>> hdl/rle_palette_sprite_decoder_core.sv
// Top level of the run-length palette sprite decoder.
`timescale 1ns / 1ps
// Decodes a run-length sprite byte stream into RGB565 pixel writes.
// req_ channel: one word per item; tuser is the action (source byte, palette
//   write, start image), tdata carries the stream byte, palette slot and color.
// csr_ channel: register writes (width, height, first skip, row skip); always
//   ready, taken in the same cycle. Write only while the decoder is idle.
// rsp_ channel: one word per opaque pixel or image completion; tdata holds
//   column, row and color, tuser marks a pixel write, tlast marks the image end.
// Flow: count, flag, hole-in-skip and palette words are taken while the
//   decoder stays idle. A word that yields a result goes through the palette
//   memory read, then the load of the output register; the result is valid
//   the cycle after that load. During a transparent run no word is taken;
//   the run unit steps through each skip drain, each row wrap and the final
//   partial row.
// Reset: control state cleared, palette reads as zero (per-entry valid bits),
//   registers at width 1, height 1, skips 0. Send a start-image word first.
// Stall: a result waits in the output register; the next word is accepted
//   meanwhile, and a new result waits in its emit cycle until the slot frees.
module rle_palette_sprite_decoder_core #(
   parameter int DIM_BITS        = rpsd_pkg::DIM_BITS_DEF,
   parameter int PALETTE_ENTRIES = rpsd_pkg::PALETTE_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] data_byte, [15:8] palette_slot, [31:16] palette_color
   input  logic [rpsd_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] action
   input  logic [rpsd_pkg::ACTION_W-1:0]   req_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rpsd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rpsd_pkg::CFG_W-1:0]      csr_data,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [11:0] pixel_column, [23:12] pixel_row, [39:24] pixel_color, [47:40] zero
   output logic [rpsd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] write_pixel
   output logic                            rsp_tuser,
   // image_done
   output logic                            rsp_tlast
);
   import rpsd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // register writes never back-pressure
   assign csr_ready = 1'b1;

   rpsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rpsd_datapath #(
      .DIM_BITS        (DIM_BITS),
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> hdl/rpsd_ctrl.sv
// Sequencing state machine: input acceptance, run stepping, result hand-off.
`timescale 1ns / 1ps
`include "rle_palette_sprite_decoder_core_macros.svh"
module rpsd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  rpsd_pkg::sts_type sts,
   output rpsd_pkg::cmd_type cmd
);
   import rpsd_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_EMIT} state_type;

   state_type state_ff;
   logic      ready_ff;

   always_comb begin
      cmd.take     = req_tvalid && ready_ff;
      cmd.run_step = (state_ff == ST_RUN);
      cmd.load_out = (state_ff == ST_EMIT) && sts.out_free;
   end

   assign req_tready = ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.take) begin
                  priority if (sts.start_run) begin
                     state_ff <= ST_RUN;
                     ready_ff <= 1'b0;
                  end else if (sts.start_emit) begin
                     state_ff <= ST_EMIT;
                     ready_ff <= 1'b0;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_RUN: begin
               priority if (sts.run_emit) begin
                  state_ff <= ST_EMIT;
               end else if (sts.run_last) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end else begin
                  state_ff <= ST_RUN;
               end
            end
            ST_EMIT: begin
               if (sts.out_free) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

   `RPSD_ASSERT_IMPL(a_ready_only_idle, ready_ff, state_ff == ST_IDLE, "ready outside idle")
   `RPSD_ASSERT_NEXT(a_emit_returns, (state_ff == ST_EMIT) && sts.out_free, ready_ff && (state_ff == ST_IDLE), "emit did not return to idle")
   `RPSD_ASSERT_IMPL(a_no_take_busy, state_ff != ST_IDLE, !cmd.take, "word taken while busy")

endmodule

>>> hdl/rpsd_datapath.sv
// Decode datapath: registers, packet parsing, position counters, palette, output register.
`timescale 1ns / 1ps
`include "rle_palette_sprite_decoder_core_macros.svh"
module rpsd_datapath #(
   parameter int DIM_BITS        = rpsd_pkg::DIM_BITS_DEF,
   parameter int PALETTE_ENTRIES = rpsd_pkg::PALETTE_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [rpsd_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [rpsd_pkg::ACTION_W-1:0]   req_tuser,
   input  logic                            csr_valid,
   input  logic [rpsd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rpsd_pkg::CFG_W-1:0]      csr_data,
   input  rpsd_pkg::cmd_type               cmd,
   output rpsd_pkg::sts_type               sts,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rpsd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);
   import rpsd_pkg::*;

   localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam int DW = DIM_BITS + 1;
   localparam int RW = (DW > BYTE_W + 1) ? DW : BYTE_W + 1;

   typedef enum logic [1:0] {PH_COUNT, PH_FLAG, PH_INDEX} phase_type;

   // configuration
   logic [CFG_W-1:0]  width_ff, height_ff;
   logic [SKIP_W-1:0] fskip_ff, rskip_ff;

   // decode state
   phase_type            phase_ff, phase_in;
   logic [BYTE_W-1:0]    count_ff, count_in;
   logic [BYTE_W-1:0]    rem_ff, rem_in;
   logic [BYTE_W-1:0]    run_n_ff, run_n_in;
   logic [SKIP_W-1:0]    skip_ff, skip_in;
   logic [DIM_BITS-1:0]  col_ff, col_in;
   logic [DIM_BITS-1:0]  row_ff, row_in;
   logic                 done_ff, done_in;

   // pending result
   logic [DIM_BITS-1:0]  pend_col_ff, pend_col_in;
   logic [DIM_BITS-1:0]  pend_row_ff, pend_row_in;
   logic                 pend_wr_ff, pend_wr_in;
   logic                 pend_done_ff, pend_done_in;

   // palette
   logic [COLOR_W-1:0]         pal_mem [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] pal_vld_ff;
   logic [COLOR_W-1:0]         rd_data_ff;
   logic                       rd_vld_ff;

   // output register
   logic                 rsp_valid_ff;
   logic [POS_W-1:0]     rsp_col_ff, rsp_row_ff;
   logic [COLOR_W-1:0]   rsp_color_ff;
   logic                 rsp_wr_ff, rsp_last_ff;

   logic [ACTION_W-1:0] action;
   logic [BYTE_W-1:0]   in_byte, in_slot;
   logic [COLOR_W-1:0]  in_color;
   logic                slot_ok, byte_ok;

   logic [DW-1:0] w_dim, h_dim;
   logic [DW-1:0] col_inc, row_inc, room;
   logic          wrap, fin;
   logic [BYTE_W-1:0] rem_src, ti_rem;
   logic          is_byte, is_index, ti_res;
   logic          rs_emit;

   function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      if (v == '0) begin
         return DW'(1);
      end else if (32'(v) > (32'd1 << DIM_BITS)) begin
         return DW'(32'd1 << DIM_BITS);
      end else begin
         return DW'(v);
      end
   endfunction

   assign action   = req_tuser;
   assign in_byte  = req_tdata[7:0];
   assign in_slot  = req_tdata[15:8];
   assign in_color = req_tdata[31:16];
   assign slot_ok  = 32'(in_slot) < PALETTE_ENTRIES;
   assign byte_ok  = 32'(in_byte) < PALETTE_ENTRIES;

   assign w_dim = clamp_dim(width_ff);
   assign h_dim = clamp_dim(height_ff);

   // one visible pixel step from the current position
   assign col_inc = {1'b0, col_ff} + DW'(1);
   assign row_inc = {1'b0, row_ff} + DW'(1);
   assign wrap    = col_inc >= w_dim;
   assign fin     = wrap && (row_inc >= h_dim);
   // pixels until the next row wrap
   assign room    = ({1'b0, col_ff} >= w_dim) ? DW'(1) : (w_dim - {1'b0, col_ff});

   assign rem_src = (phase_ff == PH_FLAG) ? count_ff : rem_ff;
   assign ti_rem  = (rem_src != '0) ? rem_src - BYTE_W'(1) : '0;

   assign is_byte  = (action == ACT_BYTE) && !done_ff;
   assign is_index = is_byte &&
                     (((phase_ff == PH_FLAG) && (in_byte != '0) && (count_ff != '0)) ||
                      ((phase_ff != PH_COUNT) && (phase_ff != PH_FLAG) && (rem_ff != '0)));
   assign ti_res   = (skip_ff == '0) && ((in_byte != '0) || fin);

   always_comb begin
      logic take_idx;
      take_idx     = 1'b0;
      rs_emit      = 1'b0;
      phase_in     = phase_ff;
      count_in     = count_ff;
      rem_in       = rem_ff;
      run_n_in     = run_n_ff;
      skip_in      = skip_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      done_in      = done_ff;
      pend_col_in  = pend_col_ff;
      pend_row_in  = pend_row_ff;
      pend_wr_in   = pend_wr_ff;
      pend_done_in = pend_done_ff;

      if (cmd.take) begin
         unique case (action)
            ACT_START: begin
               phase_in = PH_COUNT;
               count_in = '0;
               rem_in   = '0;
               skip_in  = fskip_ff;
               col_in   = '0;
               row_in   = '0;
               done_in  = 1'b0;
            end
            ACT_BYTE: begin
               if (!done_ff) begin
                  unique case (phase_ff)
                     PH_COUNT: begin
                        count_in = in_byte;
                        phase_in = PH_FLAG;
                     end
                     PH_FLAG: begin
                        priority if (in_byte == '0) begin
                           phase_in = PH_COUNT;
                           run_n_in = count_ff;
                        end else if (count_ff == '0) begin
                           // empty opaque packet: flag byte is the next count
                           count_in = in_byte;
                        end else begin
                           take_idx = 1'b1;
                        end
                     end
                     default: begin
                        if (rem_ff == '0) begin
                           count_in = in_byte;
                           phase_in = PH_FLAG;
                        end else begin
                           take_idx = 1'b1;
                        end
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase

         if (take_idx) begin
            rem_in       = ti_rem;
            phase_in     = (ti_rem == '0) ? PH_COUNT : PH_INDEX;
            pend_col_in  = col_ff;
            pend_row_in  = row_ff;
            pend_wr_in   = (in_byte != '0);
            pend_done_in = fin;
            if (skip_ff != '0) begin
               skip_in = skip_ff - SKIP_W'(1);
            end else if (wrap) begin
               col_in = '0;
               if (fin) begin
                  done_in = 1'b1;
               end else begin
                  row_in  = DIM_BITS'(row_inc);
                  skip_in = rskip_ff;
               end
            end else begin
               col_in = DIM_BITS'(col_inc);
            end
         end
      end else if (cmd.run_step) begin
         if (skip_ff != '0) begin
            if (SKIP_W'(run_n_ff) <= skip_ff) begin
               skip_in  = skip_ff - SKIP_W'(run_n_ff);
               run_n_in = '0;
            end else begin
               run_n_in = run_n_ff - BYTE_W'(skip_ff);
               skip_in  = '0;
            end
         end else if (RW'(run_n_ff) < RW'(room)) begin
            col_in   = DIM_BITS'(RW'(col_ff) + RW'(run_n_ff));
            run_n_in = '0;
         end else begin
            run_n_in = run_n_ff - BYTE_W'(room);
            col_in   = '0;
            if (row_inc >= h_dim) begin
               done_in      = 1'b1;
               run_n_in     = '0;
               rs_emit      = 1'b1;
               pend_wr_in   = 1'b0;
               pend_done_in = 1'b1;
            end else begin
               row_in  = DIM_BITS'(row_inc);
               skip_in = rskip_ff;
            end
         end
      end
   end

   always_comb begin
      sts.start_run  = is_byte && (phase_ff == PH_FLAG) && (in_byte == '0) && (count_ff != '0);
      sts.start_emit = is_index && ti_res;
      sts.run_last   = (run_n_in == '0);
      sts.run_emit   = rs_emit;
      sts.out_free   = !rsp_valid_ff || rsp_tready;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= CFG_W'(1);
         height_ff    <= CFG_W'(1);
         fskip_ff     <= '0;
         rskip_ff     <= '0;
         phase_ff     <= PH_COUNT;
         count_ff     <= '0;
         rem_ff       <= '0;
         run_n_ff     <= '0;
         skip_ff      <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         done_ff      <= 1'b0;
         pal_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               REG_WIDTH:      width_ff  <= csr_data;
               REG_HEIGHT:     height_ff <= csr_data;
               REG_FIRST_SKIP: fskip_ff  <= csr_data[SKIP_W-1:0];
               REG_ROW_SKIP:   rskip_ff  <= csr_data[SKIP_W-1:0];
               default: begin
               end
            endcase
         end
         phase_ff <= phase_in;
         count_ff <= count_in;
         rem_ff   <= rem_in;
         run_n_ff <= run_n_in;
         skip_ff  <= skip_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         done_ff  <= done_in;
         if (cmd.take && (action == ACT_PALETTE) && slot_ok) begin
            pal_vld_ff[in_slot[AW-1:0]] <= 1'b1;
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // palette memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.take && (action == ACT_PALETTE) && slot_ok) begin
         pal_mem[in_slot[AW-1:0]] <= in_color;
      end
      if (cmd.take) begin
         rd_data_ff <= pal_mem[in_byte[AW-1:0]];
         rd_vld_ff  <= pal_vld_ff[in_byte[AW-1:0]] && byte_ok;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      pend_col_ff  <= pend_col_in;
      pend_row_ff  <= pend_row_in;
      pend_wr_ff   <= pend_wr_in;
      pend_done_ff <= pend_done_in;
      if (cmd.load_out) begin
         rsp_col_ff   <= pend_wr_ff ? POS_W'(pend_col_ff) : '0;
         rsp_row_ff   <= pend_wr_ff ? POS_W'(pend_row_ff) : '0;
         rsp_color_ff <= (pend_wr_ff && rd_vld_ff) ? rd_data_ff : '0;
         rsp_wr_ff    <= pend_wr_ff;
         rsp_last_ff  <= pend_done_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {8'b0, rsp_color_ff, rsp_row_ff, rsp_col_ff};
   assign rsp_tuser  = rsp_wr_ff;
   assign rsp_tlast  = rsp_last_ff;

   `RPSD_ASSERT_IMPL(a_hole_fields_zero, rsp_valid_ff && !rsp_wr_ff, (rsp_col_ff == '0) && (rsp_row_ff == '0) && (rsp_color_ff == '0), "non-write result carries data")
   `RPSD_ASSERT_NEXT(a_run_done_latches, cmd.run_step && rs_emit, done_ff && pend_done_ff && !pend_wr_ff, "run completion not recorded")

endmodule

>>> tb/tb_rle_palette_sprite_decoder_core.sv
// Self-checking testbench for the run-length palette sprite decoder core.
`timescale 1ns / 1ps
module tb_rle_palette_sprite_decoder_core;
   import rpsd_pkg::*;

   localparam int    ITEM_TARGET  = 1750;
   localparam int    DRAIN_CYCLES = 600;     // lets the longest run finish after the last word
   localparam int    IDLE_PCT     = 34;
   localparam int    DIM_TOP      = 4096;
   localparam longint LIMIT_NS    = 64'd24_000_000;

   typedef enum logic [1:0] {AWAIT_COUNT, AWAIT_FLAG, IN_INDICES} parse_phase_type;

   typedef struct {
      logic [ACTION_W-1:0] action;
      logic [BYTE_W-1:0]   data_byte;
      logic [7:0]          slot;
      logic [COLOR_W-1:0]  color;
   } stream_word_type;

   typedef struct {
      logic [POS_W-1:0]   column;
      logic [POS_W-1:0]   row;
      logic [COLOR_W-1:0] color;
      logic               opaque;
      logic               image_end;
   } pixel_write_type;

   // ---------------------------------------------------------------- DUT ports
   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [7:0] byte, [15:8] slot, [31:16] color
   logic [ACTION_W-1:0]   req_tuser  = '0;   // [1:0] action
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CFG_W-1:0]      csr_data   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [11:0] col, [23:12] row, [39:24] color
   logic                  rsp_tuser;         // [0] write_pixel
   logic                  rsp_tlast;         // image_done

   rle_palette_sprite_decoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // ------------------------------------------------------- testbench state
   stream_word_type word_queue[$];        // words waiting for the driver
   pixel_write_type expected_pixels[$];   // predicted result words, oldest first
   int           words_queued = 0;
   int           mismatches   = 0;
   bit           word_taken   = 1'b0;  // set at the edge a req word is accepted
   bit           steady       = 1'b0;  // no idling on either side
   int           hold_cycles  = 0;     // receiver hold-off still to run

   // decoder shadow: config, palette and stream parser
   logic [CFG_W-1:0]   width_reg      = 13'd1;
   logic [CFG_W-1:0]   height_reg     = 13'd1;
   logic [SKIP_W-1:0]  first_skip_reg = '0;
   logic [SKIP_W-1:0]  row_skip_reg   = '0;
   logic [COLOR_W-1:0] palette_shadow [256] = '{default: '0};
   parse_phase_type    parse_phase    = AWAIT_COUNT;
   logic [7:0]         run_count      = '0;
   logic [7:0]         indices_left   = '0;
   int unsigned        skip_left      = 0;
   int unsigned        col_pos        = 0;
   int unsigned        row_pos        = 0;
   bit                 image_complete = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop in case a handshake never completes
   initial begin
      #(LIMIT_NS);
      $display("CHECK FAILED");
      $finish;
   end

   // ------------------------------------------------------------- predictor
   // zero reads as 1, anything above 2^DIM_BITS saturates
   function automatic int unsigned dim_eff(input logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      return (v > DIM_TOP) ? DIM_TOP : v;
   endfunction

   // step past one visible position; 1 when the last row just closed
   function automatic bit next_position();
      col_pos++;
      if (col_pos >= dim_eff(width_reg)) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= dim_eff(height_reg)) begin
            image_complete = 1'b1;
            return 1'b1;
         end
         skip_left = row_skip_reg;
      end
      return 1'b0;
   endfunction

   function automatic void push_pixel(input int unsigned c, input int unsigned r,
                                      input logic [15:0] color, input bit opaque,
                                      input bit image_end);
      pixel_write_type p;
      p.column    = c[POS_W-1:0];
      p.row       = r[POS_W-1:0];
      p.color     = color;
      p.opaque    = opaque;
      p.image_end = image_end;
      expected_pixels.push_back(p);
   endfunction

   // one palette index of an opaque packet; 0 is a hole
   function automatic void place_index(input logic [7:0] idx);
      int unsigned c;
      int unsigned r;
      bit          closed;
      c = col_pos;
      r = row_pos;
      if (indices_left != 0) indices_left--;
      if (indices_left == 0) parse_phase = AWAIT_COUNT;
      if (skip_left != 0) begin
         skip_left--;
         return;
      end
      closed = next_position();
      if (idx != 0) push_pixel(c, r, palette_shadow[idx], 1'b1, closed);
      else if (closed) push_pixel(0, 0, '0, 1'b0, 1'b1);
   endfunction

   function automatic void decode_word(input logic [ACTION_W-1:0] action,
                                       input logic [REQ_DATA_W-1:0] tdata);
      logic [7:0]  b;
      int unsigned n;
      b = tdata[7:0];
      case (action)
         ACT_PALETTE: palette_shadow[tdata[15:8]] = tdata[31:16];
         ACT_START: begin
            parse_phase    = AWAIT_COUNT;
            run_count      = '0;
            indices_left   = '0;
            skip_left      = first_skip_reg;
            col_pos        = 0;
            row_pos        = 0;
            image_complete = 1'b0;
         end
         ACT_BYTE: if (!image_complete) begin
            case (parse_phase)
               AWAIT_COUNT: begin
                  run_count   = b;
                  parse_phase = AWAIT_FLAG;
               end
               AWAIT_FLAG: if (b == 0) begin
                  // transparent run; skips swallow pixels first
                  parse_phase = AWAIT_COUNT;
                  n = run_count;
                  while (n != 0 && !image_complete) begin
                     n--;
                     if (skip_left != 0) skip_left--;
                     else if (next_position()) push_pixel(0, 0, '0, 1'b0, 1'b1);
                  end
               end else if (run_count == 0) begin
                  // empty opaque packet: flag byte becomes the next count
                  run_count = b;
               end else begin
                  indices_left = run_count;
                  parse_phase  = IN_INDICES;
                  place_index(b);
               end
               default: if (indices_left == 0) begin
                  run_count   = b;
                  parse_phase = AWAIT_FLAG;
               end else begin
                  place_index(b);
               end
            endcase
         end
         default: ;
      endcase
   endfunction

   // -------------------------------------------------------------- checking
   task automatic note_mismatch(input string what, input longint want_v,
                                input longint got_v);
      $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
      mismatches++;
   endtask

   task automatic check_pixel();
      pixel_write_type want;
      if (expected_pixels.size() == 0) begin
         note_mismatch("unexpected result word", 0, rsp_tdata);
         return;
      end
      want = expected_pixels.pop_front();
      if (rsp_tdata[11:0] != want.column) note_mismatch("pixel_column", want.column, rsp_tdata[11:0]);
      if (rsp_tdata[23:12] != want.row)   note_mismatch("pixel_row", want.row, rsp_tdata[23:12]);
      if (rsp_tdata[39:24] != want.color) note_mismatch("pixel_color", want.color, rsp_tdata[39:24]);
      if (rsp_tuser != want.opaque)       note_mismatch("write_pixel", want.opaque, rsp_tuser);
      if (rsp_tlast != want.image_end)    note_mismatch("image_done", want.image_end, rsp_tlast);
   endtask

   // monitor: sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            decode_word(req_tuser, req_tdata);
            word_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) check_pixel();
      end
   end

   // driver: present the next queued word at the falling edge, idling at random
   always @(negedge clock) begin : drive_req
      stream_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || word_taken) begin
         if (word_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            w = word_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= w.action;
            req_tdata  <= {w.color, w.slot, w.data_byte};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      word_taken = 1'b0;
   end

   // receiver: random stalls, plus a long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_cycles != 0) begin
         rsp_tready <= 1'b0;
         hold_cycles--;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // -------------------------------------------------------------- stimulus
   task automatic queue_word(input logic [ACTION_W-1:0] act, input logic [7:0] b,
                             input logic [7:0] slot, input logic [15:0] color);
      stream_word_type w;
      w.action    = act;
      w.data_byte = b;
      w.slot      = slot;
      w.color     = color;
      word_queue.push_back(w);
      if (act != ACT_SPARE) words_queued++;
   endtask

   // unused fields carry random junk; the block must ignore them
   task automatic queue_byte(input logic [7:0] b);
      queue_word(ACT_BYTE, b, 8'($urandom), 16'($urandom));
   endtask

   task automatic queue_palette(input logic [7:0] slot, input logic [15:0] color);
      queue_word(ACT_PALETTE, 8'($urandom), slot, color);
   endtask

   task automatic queue_start();
      queue_word(ACT_START, 8'($urandom), 8'($urandom), 16'($urandom));
   endtask

   task automatic queue_run(input int n);
      queue_byte(8'(n));
      queue_byte(8'd0);
   endtask

   // count, first index (doubles as the flag, never 0), then the rest with holes
   task automatic queue_opaque(input int n);
      queue_byte(8'(n));
      queue_byte(8'($urandom_range(255, 1)));
      for (int i = 1; i < n; i++)
         queue_byte(($urandom_range(99) < 15) ? 8'd0 : 8'($urandom_range(255)));
   endtask

   // one image: packets until enough source pixels have been fed, plus noise
   task automatic queue_image(input int opaque_pct, input int max_run, input int max_opaque);
      int unsigned need;
      int unsigned fed;
      int          r;
      int          n;
      need = first_skip_reg + dim_eff(width_reg) * dim_eff(height_reg)
             + (dim_eff(height_reg) - 1) * row_skip_reg;
      fed = 0;
      queue_start();
      while (fed < need + 2) begin
         r = $urandom_range(99);
         if (r < 4) begin
            queue_palette(8'($urandom), 16'($urandom));
         end else if (r < 6) begin
            queue_word(ACT_SPARE, 8'($urandom), 8'($urandom), 16'($urandom));
         end else if (r < 7) begin
            // empty opaque packet, its flag byte taken as the real count
            n = $urandom_range(6, 1);
            queue_byte(8'd0);
            queue_opaque(n);
            fed += n;
         end else if (r < 8) begin
            queue_start();       // restart mid image
            fed = 0;
         end else if (r < 9) begin
            queue_byte(8'($urandom)); // stray byte breaks packet framing
         end else if ($urandom_range(99) < opaque_pct) begin
            n = $urandom_range(max_opaque, 1);
            queue_opaque(n);
            fed += n;
         end else begin
            n = $urandom_range(max_run);
            queue_run(n);
            fed += n;
         end
      end
      // bytes after completion are ignored
      repeat (3) queue_byte(8'($urandom));
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_WIDTH:      width_reg      = value;
         REG_HEIGHT:     height_reg     = value;
         REG_FIRST_SKIP: first_skip_reg = value[SKIP_W-1:0];
         default:        row_skip_reg   = value[SKIP_W-1:0];
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                               input logic [CFG_W-1:0] first_skip,
                               input logic [CFG_W-1:0] row_skip);
      write_csr(REG_WIDTH, w);
      write_csr(REG_HEIGHT, h);
      write_csr(REG_FIRST_SKIP, first_skip);
      write_csr(REG_ROW_SKIP, row_skip);
   endtask

   // all words sent, all results seen, then room for a silent long run to end
   task automatic wait_idle();
      while (word_queue.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int phase;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: 3 wide, 2 tall, one skipped pixel at start and per row
      set_geometry(13'd3, 13'd2, 13'd1, 13'd1);
      queue_palette(8'd0, 16'hFFFF);
      queue_palette(8'd255, 16'hFFFF);
      queue_palette(8'd7, 16'h0000);
      queue_word(ACT_SPARE, 8'hFF, 8'hFF, 16'hFFFF);   // unused action
      queue_start();
      queue_run(2);                                   // skip eats one, column 1
      queue_byte(8'd0);                               // empty opaque packet:
      queue_byte(8'd3);                               //   flag 3 becomes the count
      queue_byte(8'd255);                             // top palette slot
      queue_byte(8'd0);                               // hole wraps the row
      queue_byte(8'd5);                               // swallowed by the row skip
      queue_byte(8'd3);
      queue_byte(8'd5);
      queue_byte(8'd6);
      queue_byte(8'd7);                               // pixel that ends the image
      queue_byte(8'd1);                               // ignored after completion
      queue_byte(8'd0);
      queue_start();
      queue_run(4);
      queue_run(1);
      queue_byte(8'd3);
      queue_byte(8'd9);
      queue_byte(8'd0);
      queue_byte(8'd0);                               // hole ends the image
      wait_idle();

      // fresh palette for the random part
      for (int s = 0; s < 256; s++) queue_palette(8'(s), 16'($urandom));
      wait_idle();

      phase = 0;
      // every fixed phase runs, including the hold-off one
      while (words_queued < ITEM_TARGET || phase <= 5) begin
         case (phase)
            0: begin   // widest rows, largest skips (bit 12 set in the width and first-skip writes)
               set_geometry(13'h1FFF, 13'd2, 13'h1FFF, 13'd4095);
               queue_image(10, 255, 24);
            end
            1: begin   // one column, tallest image
               set_geometry(13'd0, 13'd4096, 13'd0, 13'd0);
               queue_image(15, 255, 40);
            end
            2: begin   // every pixel completes the image
               set_geometry(13'd1, 13'd0, 13'd0, 13'd0);
               queue_image(50, 4, 4);
            end
            3: begin
               set_geometry(13'd4096, 13'd1, 13'd0, 13'd0);
               queue_image(10, 255, 30);
            end
            5: begin   // receiver holds off while opaque pixels pile up
               set_geometry(13'd12, 13'd8, 13'd2, 13'd3);
               hold_cycles = 400;
               queue_image(90, 8, 12);
            end
            default: begin
               set_geometry(($urandom_range(9) == 0) ? 13'd0 : 13'($urandom_range(12, 1)),
                            13'($urandom_range(8)), 13'($urandom_range(6)),
                            13'($urandom_range(4)));
               steady = (phase == 4);   // one long stretch without idling
               queue_image(45, 24, 10);
            end
         endcase
         wait_idle();
         steady = 1'b0;
         phase++;
      end

      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
